/* rtl/core/dtrf_pkg.sv */
// dtrf_pkg: shared constants, status codes and structs of the decimal to
// reduced fraction block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtrf_pkg;

  // Defaults and widths
  localparam int MAX_DIGITS_DEF = 17;
  localparam int VAL_W          = 64;
  localparam int CNT_W          = 5;
  localparam int DEN_W          = 63;
  localparam int STAT_W         = 2;

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MALFORMED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

  // Finished number handed from the parser to the sequencer
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  scale;
    logic              rep;
    logic [3:0]        rep_digit;
    logic              neg;
    logic [STAT_W-1:0] status;
  } job_t;

  // Shared divider request and response
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
    logic [VAL_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/dtrf_in_if.sv */
// dtrf_in_if: character input channel, valid/ready with one character item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dtrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       has_repeat;
  logic [3:0] repeat_digit;

  modport source (output valid, output char_code, output last_char,
                  output has_repeat, output repeat_digit, input ready);
  modport sink   (input valid, input char_code, input last_char,
                  input has_repeat, input repeat_digit, output ready);
endinterface

`default_nettype wire

/* rtl/core/dtrf_out_if.sv */
// dtrf_out_if: result channel, valid/ready with numerator, denominator, status.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dtrf_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] numerator;
  logic        [62:0] denominator;
  logic        [1:0]  status;

  modport source (output valid, output numerator, output denominator,
                  output status, input ready);
  modport sink   (input valid, input numerator, input denominator,
                  input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/dtrf_parser.sv */
// dtrf_parser: accumulates digit value, power of ten and error state, one
// character item per cycle while accept is high. Depends on dtrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtrf_parser #(
  parameter int unsigned MAX_DIGITS = dtrf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           char_code,
  input  wire logic                 last_char,
  input  wire logic                 has_repeat,
  input  wire logic [3:0]           repeat_digit,
  output logic                      job_valid,
  output dtrf_pkg::job_t            job
);

  localparam logic [dtrf_pkg::CNT_W-1:0] MaxCnt = dtrf_pkg::CNT_W'(MAX_DIGITS);

  logic [dtrf_pkg::VAL_W-1:0]  digit_value, digit_value_next;
  logic [dtrf_pkg::VAL_W-1:0]  scale_power, scale_power_next;
  logic [dtrf_pkg::CNT_W-1:0]  digit_count, digit_count_next;
  logic [dtrf_pkg::CNT_W-1:0]  int_digit_count, int_digit_count_next;
  logic                        seen_point, seen_point_next;
  logic                        is_negative, is_negative_next;
  logic [dtrf_pkg::STAT_W-1:0] error_code, error_code_next;
  logic [dtrf_pkg::STAT_W-1:0] final_status;
  logic                        is_digit;
  logic [3:0]                  digit;

  // '0'..'9' carry their value in the low nibble
  assign digit    = char_code[3:0];
  assign is_digit = (char_code >= dtrf_pkg::CHAR_ZERO) && (char_code <= dtrf_pkg::CHAR_NINE);

  // Per-character update, frozen after the first error
  always_comb begin
    digit_value_next     = digit_value;
    scale_power_next     = scale_power;
    digit_count_next     = digit_count;
    int_digit_count_next = int_digit_count;
    seen_point_next      = seen_point;
    is_negative_next     = is_negative;
    error_code_next      = error_code;
    if (error_code == dtrf_pkg::STAT_OK) begin
      priority if (char_code == dtrf_pkg::CHAR_MINUS) begin
        if (digit_count == '0 && !seen_point && !is_negative) begin
          is_negative_next = 1'b1;
        end else begin
          error_code_next = dtrf_pkg::STAT_MALFORMED;
        end
      end else if (char_code == dtrf_pkg::CHAR_POINT) begin
        if (seen_point) begin
          error_code_next = dtrf_pkg::STAT_MALFORMED;
        end else begin
          seen_point_next = 1'b1;
        end
      end else if (is_digit) begin
        if (digit_count >= MaxCnt) begin
          error_code_next = dtrf_pkg::STAT_OVERFLOW;
        end else begin
          digit_value_next = (digit_value << 3) + (digit_value << 1)
                             + {{(dtrf_pkg::VAL_W-4){1'b0}}, digit};
          if (seen_point) begin
            scale_power_next = (scale_power << 3) + (scale_power << 1);
          end else begin
            int_digit_count_next = int_digit_count + 1'b1;
          end
          digit_count_next = digit_count + 1'b1;
        end
      end else begin
        error_code_next = dtrf_pkg::STAT_MALFORMED;
      end
    end
  end

  // Checks that apply once the whole number is in
  always_comb begin
    final_status = error_code_next;
    if (final_status == dtrf_pkg::STAT_OK && int_digit_count_next == '0) begin
      final_status = dtrf_pkg::STAT_MALFORMED;
    end
    if (final_status == dtrf_pkg::STAT_OK && has_repeat && repeat_digit > dtrf_pkg::DIGIT_MAX) begin
      final_status = dtrf_pkg::STAT_MALFORMED;
    end
  end

  assign job_valid     = accept && last_char;
  assign job.value     = digit_value_next;
  assign job.scale     = scale_power_next;
  assign job.rep       = has_repeat;
  assign job.rep_digit = repeat_digit;
  assign job.neg       = is_negative_next;
  assign job.status    = final_status;

  // Number state, cleared after the last character
  always_ff @(posedge clk) begin
    if (rst || job_valid) begin
      digit_value     <= '0;
      scale_power     <= dtrf_pkg::VAL_W'(1);
      digit_count     <= '0;
      int_digit_count <= '0;
      seen_point      <= 1'b0;
      is_negative     <= 1'b0;
      error_code      <= dtrf_pkg::STAT_OK;
    end else if (accept) begin
      digit_value     <= digit_value_next;
      scale_power     <= scale_power_next;
      digit_count     <= digit_count_next;
      int_digit_count <= int_digit_count_next;
      seen_point      <= seen_point_next;
      is_negative     <= is_negative_next;
      error_code      <= error_code_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dtrf_div.sv */
// dtrf_div: shared restoring divider, one quotient bit per cycle, giving
// quotient and remainder. Depends on dtrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtrf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dtrf_pkg::div_req_t req,
  output dtrf_pkg::div_rsp_t      rsp
);

  localparam int W    = dtrf_pkg::VAL_W;
  localparam int CntW = $clog2(W);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    dvsr;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            fits;

  // One restoring step
  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

/* rtl/core/dtrf_seq.sv */
// dtrf_seq: sequencer that forms numerator and denominator, runs Euclid and
// the two reducing divides on the shared divider, and holds the result item.
// Depends on dtrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtrf_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           job_valid,
  input  wire dtrf_pkg::job_t                 job,
  output logic                                idle,
  output dtrf_pkg::div_req_t                  div_req,
  input  wire dtrf_pkg::div_rsp_t             div_rsp,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [dtrf_pkg::VAL_W-1:0]   numerator,
  output logic        [dtrf_pkg::DEN_W-1:0]   denominator,
  output logic        [dtrf_pkg::STAT_W-1:0]  status
);

  localparam int W = dtrf_pkg::VAL_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_GCD  = 7'b0000100,
    S_MOD  = 7'b0001000,
    S_DIVN = 7'b0010000,
    S_DIVD = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                      state, state_next;
  logic                        rep;
  logic [3:0]                  rep_digit;
  logic                        neg;
  logic [dtrf_pkg::STAT_W-1:0] stat;
  logic [W-1:0]                num_r, den_r;
  logic [W-1:0]                ga, gb;
  logic [W-1:0]                qn, qd;
  logic [W-1:0]                num9, den9;
  logic                        out_free;

  assign idle     = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Repeat digit form: (9*V + d) / (9 * 10^k)
  assign num9 = (num_r << 3) + num_r + {{(W-4){1'b0}}, rep_digit};
  assign den9 = (den_r << 3) + den_r;

  // Next state and divider requests
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = ga;
    div_req.divisor  = gb;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          state_next = (job.status == dtrf_pkg::STAT_OK) ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_next = S_GCD;
      S_GCD: begin
        div_req.start = 1'b1;
        if (gb == '0) begin
          div_req.dividend = num_r;
          div_req.divisor  = ga;
          state_next       = S_DIVN;
        end else begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (div_rsp.done) begin
          state_next = S_GCD;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = den_r;
          div_req.divisor  = ga;
          state_next       = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          num_r     <= job.value;
          den_r     <= job.scale;
          rep       <= job.rep;
          rep_digit <= job.rep_digit;
          neg       <= job.neg;
          stat      <= job.status;
          qn        <= '0;
          qd        <= '0;
        end
      end
      S_LOAD: begin
        if (rep) begin
          num_r <= num9;
          den_r <= den9;
          ga    <= num9;
          gb    <= den9;
        end else begin
          ga <= num_r;
          gb <= den_r;
        end
      end
      S_MOD: begin
        if (div_rsp.done) begin
          ga <= gb;
          gb <= div_rsp.remainder;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          qn <= div_rsp.quotient;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          qd <= div_rsp.quotient;
        end
      end
      S_GCD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded when the result slot is free
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      numerator   <= (neg && stat == dtrf_pkg::STAT_OK) ? -$signed(qn) : $signed(qn);
      denominator <= qd[dtrf_pkg::DEN_W-1:0];
      status      <= stat;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/decimal_to_reduced_fraction.sv */
// Decimal text to reduced fraction converter.
//
// in_ch takes one character item per cycle: '-', '0'..'9' or '.', with
// last_char marking the final one; on that item has_repeat and repeat_digit
// give an optional single repeating digit. out_ch gives one result item per
// number: signed numerator, denominator and status (ok, malformed, too many
// digits). Erroneous numbers report numerator and denominator as zero.
// Characters are taken at one per cycle. After the last character in_ch
// stays not ready while a shared one-bit-per-cycle 64-bit divider runs
// Euclid's remainder steps and then divides numerator and denominator by the
// GCD; an erroneous number skips the divider. in_ch is ready again as soon
// as the result sits in the output register; a stalled receiver holds that
// result, and a further finished number waits in the sequencer until the
// output register frees.
// Synchronous reset clears the number state, the sequencer and out_ch.valid.
// Depends on dtrf_pkg, dtrf_in_if, dtrf_out_if, dtrf_parser, dtrf_div, dtrf_seq.
`timescale 1ns / 1ps
`default_nettype none

module decimal_to_reduced_fraction #(
  parameter int unsigned MAX_DIGITS = dtrf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  dtrf_in_if.sink   in_ch,
  dtrf_out_if.source out_ch
);

  logic               accept;
  logic               seq_idle;
  logic               job_valid;
  dtrf_pkg::job_t     job;
  dtrf_pkg::div_req_t div_req;
  dtrf_pkg::div_rsp_t div_rsp;

  assign in_ch.ready = seq_idle;
  assign accept      = in_ch.valid && seq_idle;

  // Character accumulation
  dtrf_parser #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (in_ch.char_code),
    .last_char    (in_ch.last_char),
    .has_repeat   (in_ch.has_repeat),
    .repeat_digit (in_ch.repeat_digit),
    .job_valid    (job_valid),
    .job          (job)
  );

  // Shared divider
  dtrf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // GCD and reduction sequencer with result register
  dtrf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .idle        (seq_idle),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .numerator   (out_ch.numerator),
    .denominator (out_ch.denominator),
    .status      (out_ch.status)
  );

endmodule

`default_nettype wire

/* rtl/core/dtrf_checker.sv */
// dtrf_checker: port-level checks of the converter, bound to the top level.
// Depends on dtrf_pkg and decimal_to_reduced_fraction.
`timescale 1ns / 1ps
`default_nettype none

module dtrf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] numerator,
  input wire logic [62:0] denominator,
  input wire logic [1:0]  status
);

  // Result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A good result has a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dtrf_pkg::STAT_OK |-> denominator != '0)
    else $error("ok result with zero denominator");

  // An error result carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dtrf_pkg::STAT_OK |-> numerator == '0 && denominator == '0)
    else $error("error result with nonzero fields");

  // Status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == dtrf_pkg::STAT_OK || status == dtrf_pkg::STAT_MALFORMED
                  || status == dtrf_pkg::STAT_OVERFLOW)
    else $error("undefined status code");

  // Input closes after the final character while the number is reduced
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input ready right after final character");

endmodule

bind decimal_to_reduced_fraction dtrf_checker u_dtrf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_char),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .numerator   (out_ch.numerator),
  .denominator (out_ch.denominator),
  .status      (out_ch.status)
);

`default_nettype wire
